### design/nsrw_pkg.sv
// ----------------------------------------------------------------------------
// nsrw_pkg
// Shared types, constants and glyph functions for the number to segment
// display-memory writer.
// ----------------------------------------------------------------------------
package nsrw_pkg;

	localparam int DIGITS_DEF = 6;
	localparam int VALUE_W    = 32;
	localparam int BCD_DIGITS = 10;
	localparam int ADDR_W     = 5;
	localparam int CLEAR_LAST = 31;

	localparam logic [4:0] CODE_MINUS = 5'd17;
	localparam logic [7:0] SEGS_MINUS = 8'h40;
	localparam logic [7:0] SEGS_POINT = 8'h80;
	localparam logic [7:0] SEGS_BLANK = 8'h00;

	typedef enum logic [1:0] {
		OP_DEC   = 2'd0,
		OP_HEX   = 2'd1,
		OP_GLYPH = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t                opcode;
		logic [VALUE_W-1:0] value;
		logic               pad_with_zero;
		logic [2:0]         position;
		logic [4:0]         digit_code;
		logic               point_on;
	} in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [3:0]        write_nibble;
		logic              last_write;
	} out_t;

	function automatic logic [7:0] hex_segs(input logic [3:0] nib);
		logic [7:0] s;
		case (nib)
			4'h0: s = 8'h3F;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5B;
			4'h3: s = 8'h4F;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6D;
			4'h6: s = 8'h7D;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h6F;
			4'hA: s = 8'h77;
			4'hB: s = 8'h7C;
			4'hC: s = 8'h39;
			4'hD: s = 8'h5E;
			4'hE: s = 8'h79;
			default: s = 8'h71;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] code_segs(input logic [4:0] code, input logic point);
		logic [7:0] s;
		if (!code[4]) begin
			s = hex_segs(code[3:0]);
		end else if (code == CODE_MINUS) begin
			s = SEGS_MINUS;
		end else begin
			s = SEGS_BLANK;
		end
		if (point) begin
			s = s | SEGS_POINT;
		end
		return s;
	endfunction

endpackage

### design/number_to_segment_ram_writer_top.sv
// ----------------------------------------------------------------------------
// number_to_segment_ram_writer_top
// Turns a number, single glyph or clear request into nibble writes to a seven-segment
// display memory. Decimal conversion is bit-serial double dabble.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request per transfer; the block takes a
//   request only when the previous one has produced all its writes (the final
//   write may still sit in the output register).
//   out_valid/out_ready/out_data carry one nibble write per transfer, with
//   last_write set on the final write of a request.
//   Writes per request; emission runs one write per cycle unless the receiver stalls:
//     signed decimal : 2*DIGITS, after the magnitude is shifted one bit per cycle
//                      into the BCD shift register
//     hex            : 2*DIGITS
//     single glyph   : 2, or none when position >= DIGITS
//     clear          : 32
//   Each write passes through the output register before it appears.
//   Reset returns the controller to idle and empties the output register.
//   A stalled receiver holds the current write; emission pauses until it is
//   taken.
// ----------------------------------------------------------------------------
module number_to_segment_ram_writer_top #(
	parameter int DIGITS = nsrw_pkg::DIGITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  nsrw_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output nsrw_pkg::out_t  out_data
);

	localparam int VW = nsrw_pkg::VALUE_W;
	localparam int BD = nsrw_pkg::BCD_DIGITS;
	localparam int AW = nsrw_pkg::ADDR_W;
	localparam logic [AW-1:0] GLYPH_LAST = AW'(2 * DIGITS - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CONV = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                  state_q;
	nsrw_pkg::op_t           op_q;
	logic [VW-1:0]           shreg_q;
	logic [BD-1:0][3:0]      bcd_q;
	logic [4:0]              bit_cnt_q;
	logic [AW-1:0]           wr_cnt_q;
	logic                    neg_q;
	logic                    pad_q;
	logic [2:0]              pos_q;
	logic [4:0]              code_q;
	logic                    point_q;
	logic                    out_valid_q;
	nsrw_pkg::out_t          out_q;

	logic                    load;
	logic [BD-1:0][3:0]      bcd_next;
	logic [3:0]              ndig;
	logic [3:0]              dcount;
	logic [2:0]              gpos;
	logic [3:0]              k;
	logic [2:0]              didx;
	logic [7:0][3:0]         nibs;
	logic [7:0]              segs;
	logic [AW-1:0]           last_idx;
	nsrw_pkg::out_t          wr;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign load      = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// double dabble step: add 3 to digits of 5 or more, then shift in next bit
	always_comb begin
		logic [BD-1:0][3:0] adj;
		logic [BD*4:0]      shifted;
		for (int i = 0; i < BD; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		shifted  = {adj, shreg_q[VW-1]};
		bcd_next = shifted[BD*4-1:0];
	end

	always_comb begin
		ndig = 4'd1;
		for (int i = 0; i < BD; i++) begin
			if (bcd_q[i] != 4'd0) begin
				ndig = 4'(i + 1);
			end
		end
		dcount = (ndig > 4'(DIGITS)) ? 4'(DIGITS) : ndig;
	end

	always_comb begin
		gpos = wr_cnt_q[3:1];
		k    = {1'b0, gpos} - {3'b000, neg_q};
		didx = 3'(dcount - 4'd1 - k);
		for (int i = 0; i < 8; i++) begin
			nibs[i] = shreg_q[i*4 +: 4];
		end
		case (op_q)
			nsrw_pkg::OP_DEC: begin
				if (neg_q && gpos == 3'd0) begin
					segs = nsrw_pkg::SEGS_MINUS;
				end else if (k < dcount) begin
					segs = nsrw_pkg::hex_segs(bcd_q[{1'b0, didx}]);
				end else begin
					segs = pad_q ? nsrw_pkg::hex_segs(4'd0) : nsrw_pkg::SEGS_BLANK;
				end
			end
			nsrw_pkg::OP_HEX:   segs = nsrw_pkg::hex_segs(nibs[3'(DIGITS - 1) - gpos]);
			nsrw_pkg::OP_GLYPH: segs = nsrw_pkg::code_segs(code_q, point_q);
			default:            segs = nsrw_pkg::SEGS_BLANK;
		endcase
		case (op_q)
			nsrw_pkg::OP_GLYPH: last_idx = AW'(1);
			nsrw_pkg::OP_CLEAR: last_idx = AW'(nsrw_pkg::CLEAR_LAST);
			default:            last_idx = GLYPH_LAST;
		endcase
		wr.write_address = (op_q == nsrw_pkg::OP_GLYPH) ? {1'b0, pos_q, wr_cnt_q[0]} : wr_cnt_q;
		wr.write_nibble  = wr_cnt_q[0] ? segs[7:4] : segs[3:0];
		wr.last_write    = (wr_cnt_q == last_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.opcode)
							nsrw_pkg::OP_DEC: state_q <= S_CONV;
							nsrw_pkg::OP_GLYPH: begin
								if ({1'b0, in_data.position} < 4'(DIGITS)) begin
									state_q <= S_EMIT;
								end
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_CONV: begin
					if (bit_cnt_q == 5'(VW - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load && wr.last_write) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q    <= wr;
			wr_cnt_q <= wr_cnt_q + AW'(1);
		end
		case (state_q)
			S_IDLE: begin
				op_q      <= in_data.opcode;
				neg_q     <= (in_data.opcode == nsrw_pkg::OP_DEC) && in_data.value[VW-1];
				shreg_q   <= ((in_data.opcode == nsrw_pkg::OP_DEC) && in_data.value[VW-1]) ?
				             (VW'(0) - in_data.value) : in_data.value;
				pad_q     <= in_data.pad_with_zero;
				pos_q     <= in_data.position;
				code_q    <= in_data.digit_code;
				point_q   <= in_data.point_on;
				bcd_q     <= '0;
				bit_cnt_q <= '0;
				wr_cnt_q  <= '0;
			end
			S_CONV: begin
				bcd_q     <= bcd_next;
				shreg_q   <= {shreg_q[VW-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + 5'd1;
			end
			default: ;
		endcase
	end

endmodule

### design/nsrw_checker.sv
// ----------------------------------------------------------------------------
// nsrw_assertions
// Port-level checks for the number to segment display-memory writer.
// ----------------------------------------------------------------------------
module nsrw_assertions (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input nsrw_pkg::in_t   in_data,
	input logic            out_valid,
	input logic            out_ready,
	input nsrw_pkg::out_t  out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transfer changed while stalled");

	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_write |-> !in_ready)
		else $error("request taken before previous writes finished");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == nsrw_pkg::OP_CLEAR |=> !in_ready)
		else $error("clear request did not start emission");

	a_hex_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == nsrw_pkg::OP_HEX |=> !in_ready)
		else $error("hex request did not start emission");

endmodule

bind number_to_segment_ram_writer_top nsrw_assertions u_nsrw_assertions (.*);

### sim/nsrw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsrw_checker
// Watches both transfer channels of the segment display-memory writer. Each
// accepted request is expanded into the nibble writes it should cause, and
// every accepted write is compared against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module nsrw_checker #(
	parameter int DIGITS = nsrw_pkg::DIGITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  nsrw_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  nsrw_pkg::out_t out_data,
	output int             mismatches,
	output int             writes_pending,
	output int             writes_seen
);

	// segment patterns for 0-F, F in the top byte
	localparam logic [127:0] DIGIT_SEGS = {
		8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
		8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};
	localparam logic [7:0] GLYPH_DASH  = 8'h40;
	localparam logic [7:0] GLYPH_DOT   = 8'h80;
	localparam logic [7:0] GLYPH_BLANK = 8'h00;
	localparam int         CLEAR_SPAN  = 32;

	nsrw_pkg::out_t expected_writes[$];
	nsrw_pkg::out_t want;

	initial begin
		mismatches     = 0;
		writes_pending = 0;
		writes_seen    = 0;
	end

	function automatic logic [7:0] digit_segs(input logic [3:0] d);
		return DIGIT_SEGS[int'(d) * 8 +: 8];
	endfunction

	function automatic void queue_glyph(input int pos, input logic [7:0] segs);
		nsrw_pkg::out_t w;
		w.write_address = {pos[3:0], 1'b0};
		w.write_nibble  = segs[3:0];
		w.last_write    = 1'b0;
		expected_writes.push_back(w);
		w.write_address = {pos[3:0], 1'b1};
		w.write_nibble  = segs[7:4];
		expected_writes.push_back(w);
	endfunction

	function automatic void predict_writes(input nsrw_pkg::in_t req);
		logic [31:0]    mag;
		logic [3:0]     digs [8];
		logic [7:0]     segs;
		int             count;
		int             pos;
		int             start_size;
		nsrw_pkg::out_t w;
		start_size = expected_writes.size();
		count      = 0;
		pos        = 0;
		case (req.opcode)
			nsrw_pkg::OP_DEC: begin
				mag = req.value[31] ? (~req.value + 32'd1) : req.value;
				if (mag == 32'd0) begin
					digs[0] = 4'd0;
					count   = 1;
				end else begin
					while (mag != 32'd0 && count < DIGITS) begin
						digs[count] = 4'(mag % 32'd10);
						mag         = mag / 32'd10;
						count++;
					end
				end
				if (req.value[31]) begin
					queue_glyph(pos, GLYPH_DASH);
					pos++;
				end
				// with the sign shown, the lowest digit falls off the end
				while (count > 0 && pos < DIGITS) begin
					count--;
					queue_glyph(pos, digit_segs(digs[count]));
					pos++;
				end
				while (pos < DIGITS) begin
					queue_glyph(pos, req.pad_with_zero ? digit_segs(4'd0) : GLYPH_BLANK);
					pos++;
				end
			end
			nsrw_pkg::OP_HEX: begin
				for (pos = 0; pos < DIGITS; pos++) begin
					queue_glyph(pos, digit_segs(req.value[(DIGITS - 1 - pos) * 4 +: 4]));
				end
			end
			nsrw_pkg::OP_GLYPH: begin
				if (req.position < DIGITS) begin
					if (!req.digit_code[4]) begin
						segs = digit_segs(req.digit_code[3:0]);
					end else if (req.digit_code == nsrw_pkg::CODE_MINUS) begin
						segs = GLYPH_DASH;
					end else begin
						segs = GLYPH_BLANK;
					end
					if (req.point_on) begin
						segs = segs | GLYPH_DOT;
					end
					queue_glyph(int'(req.position), segs);
				end
			end
			default: begin
				for (pos = 0; pos < CLEAR_SPAN; pos++) begin
					w.write_address = pos[4:0];
					w.write_nibble  = 4'd0;
					w.last_write    = 1'b0;
					expected_writes.push_back(w);
				end
			end
		endcase
		if (expected_writes.size() > start_size) begin
			w            = expected_writes.pop_back();
			w.last_write = 1'b1;
			expected_writes.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_writes(in_data);
			end
			if (out_valid && out_ready) begin
				writes_seen++;
				if (expected_writes.size() == 0) begin
					$display("%0t: unexpected write: addr %0d nibble %h last %b", $time,
						out_data.write_address, out_data.write_nibble, out_data.last_write);
					mismatches++;
				end else begin
					want = expected_writes.pop_front();
					if (out_data !== want) begin
						$display("%0t: mismatch: exp addr %0d nib %h last %b, got %0d %h %b",
							$time, want.write_address, want.write_nibble, want.last_write,
							out_data.write_address, out_data.write_nibble, out_data.last_write);
						mismatches++;
					end
				end
			end
			writes_pending = expected_writes.size();
		end
	end

endmodule

### sim/tb_number_to_segment_ram_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_to_segment_ram_writer_top
// Drives decimal, hex, single glyph and clear requests into the writer, first
// a directed set of corner cases and then random traffic, with random idling
// on both channels. Checking is left to the checker alongside the block.
// ----------------------------------------------------------------------------
module tb_number_to_segment_ram_writer_top;

	localparam int DIGITS         = nsrw_pkg::DIGITS_DEF;
	localparam int RANDOM_ITEMS   = 480;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 64;
	localparam logic [4:0] DIGIT_BLANK = 5'd16;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	nsrw_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	nsrw_pkg::out_t out_data;

	int  mismatches;
	int  writes_pending;
	int  writes_seen;
	int  quiet_cycles;
	int  op_tally [4];
	bit  no_idle;

	number_to_segment_ram_writer_top #(
		.DIGITS(DIGITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	nsrw_checker #(
		.DIGITS(DIGITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.mismatches    (mismatches),
		.writes_pending(writes_pending),
		.writes_seen   (writes_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 33);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("FAIL number_to_segment_ram_writer_top");
				$finish;
			end
		end
	end

	function automatic nsrw_pkg::in_t make_req(input nsrw_pkg::op_t op, input logic [31:0] v,
		input logic pad, input logic [2:0] pos, input logic [4:0] code, input logic pt);
		nsrw_pkg::in_t r;
		r.opcode        = op;
		r.value         = v;
		r.pad_with_zero = pad;
		r.position      = pos;
		r.digit_code    = code;
		r.point_on      = pt;
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		int          k;
		case ($urandom_range(0, 5))
			0: pick_value = $urandom_range(0, 99);
			1: pick_value = $urandom_range(0, 999999);
			2: pick_value = -$urandom_range(1, 9999999);
			3: pick_value = $urandom;
			4: begin
				p = 32'd1;
				k = $urandom_range(0, 9);
				repeat (k) p = p * 32'd10;
				p = p + $urandom_range(0, 2) - 32'd1;
				pick_value = $urandom_range(0, 1) ? -p : p;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: pick_value = 32'h0000_0000;
					1: pick_value = 32'h0000_0001;
					2: pick_value = 32'hFFFF_FFFF;
					3: pick_value = 32'h8000_0000;
					default: pick_value = 32'h7FFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic nsrw_pkg::in_t random_req();
		nsrw_pkg::op_t op;
		int            r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			op = nsrw_pkg::OP_DEC;
		end else if (r < 65) begin
			op = nsrw_pkg::OP_HEX;
		end else if (r < 92) begin
			op = nsrw_pkg::OP_GLYPH;
		end else begin
			op = nsrw_pkg::OP_CLEAR;
		end
		return make_req(op, pick_value(), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
			5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic send_request(input nsrw_pkg::in_t req);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		op_tally[req.opcode]++;
	endtask

	initial begin
		nsrw_pkg::in_t directed [$];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		no_idle      = 1'b0;
		quiet_cycles = 0;
		foreach (op_tally[i]) op_tally[i] = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed.push_back(make_req(nsrw_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 3'd7, 5'd31, 1'b1));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'd0, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'd0, 1'b1, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'hFFFF_FFFF, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'h8000_0000, 1'b1, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'h7FFF_FFFF, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'd123, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, -32'd12345, 1'b1, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, -32'd123456, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'd999999, 1'b1, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_DEC, 32'd1000000, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_HEX, 32'h0000_0000, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_HEX, 32'hFFFF_FFFF, 1'b1, 3'd7, 5'd31, 1'b1));
		directed.push_back(make_req(nsrw_pkg::OP_HEX, 32'h1234_5678, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_HEX, 32'h89AB_CDEF, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd0, 5'd0, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd5, 5'd15, 1'b1));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd1, DIGIT_BLANK, 1'b1));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd2, nsrw_pkg::CODE_MINUS,
			1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd3, 5'd18, 1'b1));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd4, 5'd31, 1'b0));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd6, 5'd8, 1'b1));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'hFFFF_FFFF, 1'b1, 3'd7, 5'd9, 1'b1));
		directed.push_back(make_req(nsrw_pkg::OP_GLYPH, 32'd0, 1'b0, 3'd5, 5'd10, 1'b0));

		foreach (directed[i]) send_request(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// one long stretch with both sides running flat out
			no_idle = (n >= 150 && n < 250);
			send_request(random_req());
		end
		no_idle = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		while (writes_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d decimal, %0d hex, %0d glyph and %0d clear requests,",
			op_tally[nsrw_pkg::OP_DEC], op_tally[nsrw_pkg::OP_HEX],
			op_tally[nsrw_pkg::OP_GLYPH], op_tally[nsrw_pkg::OP_CLEAR]);
		$display("with %0d nibble writes checked and %0d mismatches.", writes_seen, mismatches);
		if (mismatches == 0 && writes_pending == 0) begin
			$display("PASS number_to_segment_ram_writer_top");
		end else begin
			$display("FAIL number_to_segment_ram_writer_top");
		end
		$finish;
	end

endmodule
